>>> hdl/stt_pkg.sv
// Package for the source text tokenizer: item types, token and class codes,
// and the character classifier. No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam int unsigned OffsetBits = 16;
  localparam int unsigned TokW       = 16;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic ModeByte = 1'b0;
  localparam logic ModeEnd  = 1'b1;

  typedef logic [OffsetBits-1:0] offset_t;

  typedef enum logic [2:0] {
    TK_IDENT = 3'd0,
    TK_INT   = 3'd1,
    TK_OP    = 3'd2,
    TK_SEP   = 3'd3,
    TK_END   = 3'd4,
    TK_BAD   = 3'd5,
    TK_OVF   = 3'd6
  } token_kind_e;

  typedef enum logic [1:0] {
    SC_NONE  = 2'd0,
    SC_IDENT = 2'd1,
    SC_INT   = 2'd2,
    SC_OP    = 2'd3
  } scan_class_e;

  typedef enum logic [2:0] {
    CC_SPACE,
    CC_ALPHA,
    CC_DIGIT,
    CC_OP,
    CC_SEP,
    CC_BAD
  } char_class_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      token_kind;
    logic [TokW-1:0] token_start;
    logic [TokW-1:0] token_length;
    logic [7:0]      bad_byte;
    logic            last_of_run;
  } out_item_t;

  // Results produced by one item, in order; num tells how many are valid.
  typedef struct packed {
    logic [1:0]      num;
    out_item_t [1:0] res;
  } res_pair_t;

  // Underscore counts as a letter since it may start an identifier.
  function automatic char_class_e classify(input logic [7:0] c);
    char_class_e cls;
    cls = CC_BAD;
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_") begin
      cls = CC_ALPHA;
    end else if (c >= "0" && c <= "9") begin
      cls = CC_DIGIT;
    end else begin
      case (c)
        " ", 8'h09, 8'h0A, 8'h0D: cls = CC_SPACE;
        "+", "-", "*", "/", "%", "&", "|", "^", "=", "!", ">", "<", ".", "~":
          cls = CC_OP;
        "(", ")", "{", "}", "[", "]", ",", ";": cls = CC_SEP;
        default: cls = CC_BAD;
      endcase
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

>>> hdl/stt_scan.sv
// Scanner: input item register, token state and the single-pass decision logic.
// Depends on stt_pkg; hands up to two results per item to the result queue.
`timescale 1ns / 1ps
`default_nettype none

module stt_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  stt_pkg::in_item_t  in_item_i,
  input  logic               room_i,
  output stt_pkg::res_pair_t push_o
);
  import stt_pkg::*;

  logic        item_valid_q, item_valid_d;
  in_item_t    item_q;
  scan_class_e class_q, class_d;
  offset_t     begin_q, begin_d;
  offset_t     position_q, position_d;
  logic        stuck_q, stuck_d;

  logic        fire, accept, cont, has_flush, has_extra;
  char_class_e cls;
  out_item_t   flush_res, extra_res;
  offset_t     span;

  assign fire       = item_valid_q && room_i;
  assign in_stall_o = item_valid_q && !room_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (fire) begin
      item_valid_d = 1'b0;
    end
  end

  assign cls  = classify(item_q.text_byte);
  assign span = position_q - begin_q;

  always_comb begin
    unique case (class_q)
      SC_IDENT: cont = (cls == CC_ALPHA) || (cls == CC_DIGIT);
      SC_INT:   cont = (cls == CC_DIGIT);
      SC_OP:    cont = (cls == CC_OP);
      default:  cont = 1'b0;
    endcase
  end

  always_comb begin
    flush_res = '0;
    unique case (class_q)
      SC_IDENT: flush_res.token_kind = TK_IDENT;
      SC_INT:   flush_res.token_kind = TK_INT;
      default:  flush_res.token_kind = TK_OP;
    endcase
    flush_res.token_start  = TokW'(begin_q);
    flush_res.token_length = TokW'(span);
  end

  always_comb begin
    has_flush  = 1'b0;
    has_extra  = 1'b0;
    extra_res  = '0;
    class_d    = class_q;
    begin_d    = begin_q;
    position_d = position_q;
    stuck_d    = stuck_q;
    if (fire) begin
      if (item_q.mode == ModeEnd) begin
        has_flush             = !stuck_q && (class_q != SC_NONE);
        has_extra             = 1'b1;
        extra_res.token_kind  = TK_END;
        extra_res.token_start = TokW'(position_q);
        class_d               = SC_NONE;
        begin_d               = '0;
        position_d            = '0;
        stuck_d               = 1'b0;
      end else if (!stuck_q) begin
        if (&position_q) begin
          // Offset counter is exhausted: report it and stop scanning.
          has_flush             = (class_q != SC_NONE);
          has_extra             = 1'b1;
          extra_res.token_kind  = TK_OVF;
          extra_res.token_start = TokW'(position_q);
          class_d               = SC_NONE;
          stuck_d               = 1'b1;
        end else begin
          if (!cont) begin
            has_flush = (class_q != SC_NONE);
            class_d   = SC_NONE;
            unique case (cls)
              CC_SPACE: ;
              CC_ALPHA: begin
                class_d = SC_IDENT;
                begin_d = position_q;
              end
              CC_DIGIT: begin
                class_d = SC_INT;
                begin_d = position_q;
              end
              CC_OP: begin
                class_d = SC_OP;
                begin_d = position_q;
              end
              CC_SEP: begin
                has_extra              = 1'b1;
                extra_res.token_kind   = TK_SEP;
                extra_res.token_start  = TokW'(position_q);
                extra_res.token_length = TokW'(1);
              end
              default: begin
                has_extra              = 1'b1;
                extra_res.token_kind   = TK_BAD;
                extra_res.token_start  = TokW'(position_q);
                extra_res.token_length = TokW'(1);
                extra_res.bad_byte     = item_q.text_byte;
                stuck_d                = 1'b1;
              end
            endcase
          end
          // A bad byte leaves the offset where it was.
          if (!(!cont && cls == CC_BAD)) begin
            position_d = position_q + offset_t'(1);
          end
        end
      end
    end
  end

  always_comb begin
    push_o     = '0;
    push_o.num = {1'b0, has_flush} + {1'b0, has_extra};
    if (has_flush) begin
      push_o.res[0]             = flush_res;
      push_o.res[0].last_of_run = !has_extra;
      push_o.res[1]             = extra_res;
    end else begin
      push_o.res[0] = extra_res;
    end
    push_o.res[1].last_of_run = 1'b1;
    push_o.res[0].last_of_run = has_flush ? !has_extra : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      class_q      <= SC_NONE;
      begin_q      <= '0;
      position_q   <= '0;
      stuck_q      <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      class_q      <= class_d;
      begin_q      <= begin_d;
      position_q   <= position_d;
      stuck_q      <= stuck_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_q.mode == ModeEnd |=>
      position_q == '0 && !stuck_q && class_q == SC_NONE)
    else $error("state not cleared after end of text");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_q.mode == ModeByte && stuck_q |-> push_o.num == 2'd0)
    else $error("result produced while stuck on error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.num != 2'd0 |-> fire)
    else $error("results pushed without a processed item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(position_q) && $stable(stuck_q))
    else $error("scan state changed without an item");

endmodule

`default_nettype wire

>>> hdl/stt_res_fifo.sv
// Result queue: takes up to two results per cycle from the scanner and hands
// them out one per cycle unless stalled. Depends on stt_pkg for result types and depth.
`timescale 1ns / 1ps
`default_nettype none

module stt_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stt_pkg::res_pair_t  push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stt_pkg::out_item_t  out_item_o
);
  import stt_pkg::*;

  out_item_t           mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic                pop;

  // Room is judged on the registered count so the stall has no path from the output.
  assign room_o      = (count_q <= FifoCntW'(FifoDepth - 2));
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop);
    count_d  = count_q + FifoCntW'(push_i.num) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res[0];
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + FifoPtrW'(1)] <= push_i.res[1];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth))
    else $error("result queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> room_o)
    else $error("results pushed without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.num == 2'd0 |=> count_q == $past(count_q) - FifoCntW'(1))
    else $error("queue count wrong after a pop");

endmodule

`default_nettype wire

>>> hdl/source_text_tokenizer_core.sv
// Top level of the source text tokenizer: scanner plus result queue.
// Depends on stt_pkg, stt_scan and stt_res_fifo.
//
// Usage: feed one item per cycle on the input channel (in_valid_i, in_stall_o,
// in_item_i): a text byte with mode 0, or an end-of-text mark with mode 1.
// Tokens leave on the output channel (out_valid_o, out_stall_i, out_item_o) as
// kind, start offset, length and, for a bad character, the byte itself; the
// token text stays in the caller's memory. last_of_run marks the last result
// of an item. An item is registered on acceptance and decided once the result
// queue has room. Throughput is one item per cycle while items give at most
// one result each and the output is not stalled; an item that closes a token
// and also gives a separator, error, end-of-text or overflow result gives two,
// and the output port hands out one result per cycle. Input stalls only when
// the four-entry result queue cannot take two more results. A stalled output
// holds its item; results are never dropped.
// Reset clears the token state and the offset to 0 and empties the queue.
// After a bad character or an offset overflow, bytes are ignored until the
// end-of-text item, which also returns the offset to 0.
`timescale 1ns / 1ps
`default_nettype none

module source_text_tokenizer_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  stt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output stt_pkg::out_item_t out_item_o
);
  import stt_pkg::*;

  res_pair_t push;
  logic      room;

  stt_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .room_i     (room),
    .push_o     (push)
  );

  stt_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
